@@ design/weighted_word_checksum_hash_macros.svh @@
// Assertion macros shared by the weighted word checksum hash design.
`ifndef WEIGHTED_WORD_CHECKSUM_HASH_MACROS_SVH
`define WEIGHTED_WORD_CHECKSUM_HASH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WWCH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wwch same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WWCH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wwch next-cycle check failed");

`endif

@@ design/wwch_pkg.sv @@
// Package with shared types and constants for the weighted word checksum hash.
package wwch_pkg;

	localparam int WORD_W   = 32;
	localparam int SKIP_W   = 10;
	localparam int WEIGHT_W = 17;

	localparam logic [SKIP_W-1:0] SKIP_RESET = 10'd10;
	localparam logic [WORD_W-1:0] HASH_SEED  = 32'h0000_003d;
	localparam logic [WORD_W-1:0] HASH_MUL   = 32'd668265261;

	typedef struct packed {
		logic [WORD_W-1:0]   word;
		logic [WEIGHT_W-1:0] weight;
		logic                last;
		logic                too_long;
	} wwch_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} wwch_fifo_status_t;

endpackage

@@ design/weighted_word_checksum_hash.sv @@
// Top level of the weighted word checksum hash: front end, queue and back end.
// Each record arrives as a stream of 32-bit words, one item per cycle at best, ending on the
// item with last set; one checksum item leaves per record. The front end takes an item in
// every cycle that the queue has room, and the back end drains the queue at one item per
// cycle whenever the result register is free, so the sustained rate is one item per cycle
// unless the output side stalls. The multiply stage loads as the last word of a record leaves
// the queue, and the result becomes valid after the accumulate, two hash multiply stages and
// the result register; a word is written into a queue slot before it can leave the queue.
// Words past MAX_WORDS in a record are left out of the sum and set too_long. The skip
// position register is to be written only while the block is idle, which the block itself
// does not enforce; it resets to ten.
module weighted_word_checksum_hash import wwch_pkg::*; #(
	parameter int MAX_WORDS   = 1024,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [SKIP_W-1:0] cfg_wr_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [WORD_W-1:0] word,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [WORD_W-1:0] checksum,
	output logic              too_long
);

	logic              push;
	logic              pop;
	wwch_entry_t       wr_entry;
	wwch_entry_t       rd_entry;
	wwch_fifo_status_t fifo_status;

	wwch_front #(
		.MAX_WORDS(MAX_WORDS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.word        (word),
		.last        (last),
		.fifo_status (fifo_status),
		.in_ready    (in_ready),
		.push        (push),
		.entry       (wr_entry)
	);

	wwch_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.status   (fifo_status)
	);

	wwch_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_entry    (rd_entry),
		.fifo_status (fifo_status),
		.pop         (pop),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.checksum    (checksum),
		.too_long    (too_long)
	);

`include "weighted_word_checksum_hash_macros.svh"

	`WWCH_ASSERT_SAME(a_no_overrun, clk, arst_n, push, !fifo_status.full)
	`WWCH_ASSERT_SAME(a_no_underrun, clk, arst_n, pop, !fifo_status.empty)
	`WWCH_ASSERT_SAME(a_accept_pushes, clk, arst_n, in_valid && in_ready, push)
	`WWCH_ASSERT_NEXT(a_push_fills, clk, arst_n, push && !pop, !fifo_status.empty)

endmodule

@@ design/wwch_front.sv @@
// Front end: accepts words, tracks position and overflow, and assigns each word its weight.
module wwch_front import wwch_pkg::*; #(
	parameter int MAX_WORDS = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [SKIP_W-1:0]      cfg_wr_data,
	input  logic                   in_valid,
	input  logic [WORD_W-1:0]      word,
	input  logic                   last,
	input  wwch_fifo_status_t      fifo_status,
	output logic                   in_ready,
	output logic                   push,
	output wwch_entry_t            entry
);

	localparam int CNT_W = $clog2(MAX_WORDS + 1);

	logic [SKIP_W-1:0]   skip_q;
	logic [CNT_W-1:0]    pos_q;
	logic                ovf_q;
	logic [WEIGHT_W-1:0] pos_ext;
	logic                at_max;
	logic                skip_hit;

	assign in_ready = !fifo_status.full;
	assign push     = in_valid && in_ready;

	assign pos_ext  = WEIGHT_W'(pos_q);
	assign at_max   = pos_q >= CNT_W'(MAX_WORDS);
	assign skip_hit = pos_ext == WEIGHT_W'(skip_q);

	always_comb begin
		entry.word     = word;
		entry.last     = last;
		entry.too_long = ovf_q || at_max;
		if (at_max || skip_hit) begin
			entry.weight = '0;
		end else begin
			entry.weight = pos_ext + WEIGHT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= SKIP_RESET;
		end else if (cfg_wr_en) begin
			skip_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ovf_q <= 1'b0;
		end else if (push) begin
			if (last) begin
				pos_q <= '0;
				ovf_q <= 1'b0;
			end else if (at_max) begin
				ovf_q <= 1'b1;
			end else begin
				pos_q <= pos_q + CNT_W'(1);
			end
		end
	end

endmodule

@@ design/wwch_fifo.sv @@
// Short queue of weighted words between the front end and the back end.
module wwch_fifo import wwch_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wwch_entry_t       wr_entry,
	input  logic              pop,
	output wwch_entry_t       rd_entry,
	output wwch_fifo_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	wwch_entry_t      slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.full  = count_q == CNT_W'(DEPTH);
	assign status.empty = count_q == '0;
	assign rd_entry     = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ design/wwch_back.sv @@
// Back end: multiplies, accumulates and runs the hash finalizer, with the result register.
module wwch_back import wwch_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  wwch_entry_t       rd_entry,
	input  wwch_fifo_status_t fifo_status,
	output logic              pop,
	input  logic              out_ready,
	output logic              out_valid,
	output logic [WORD_W-1:0] checksum,
	output logic              too_long
);

	logic                       adv;
	logic [WORD_W+WEIGHT_W-1:0] prod_full;
	logic [WORD_W-1:0]          sum_next;
	logic [WORD_W-1:0]          mix_in;
	logic [WORD_W-1:0]          shuf_in;
	logic [2*WORD_W-1:0]        mul_full;

	logic                valid_s1, last_s1, ovf_s1;
	logic [WORD_W-1:0]   prod_s1;
	logic [WORD_W-1:0]   sum_q;
	logic                valid_s2, ovf_s2;
	logic [WORD_W-1:0]   fin_s2;
	logic                valid_s3, ovf_s3;
	logic [WORD_W-1:0]   mix_s3;
	logic                valid_s4, ovf_s4;
	logic [WORD_W-1:0]   mul_s4;
	logic                out_valid_q, too_long_q;
	logic [WORD_W-1:0]   checksum_q;

	assign adv       = !out_valid_q || out_ready;
	assign pop       = adv && !fifo_status.empty;
	assign out_valid = out_valid_q;
	assign checksum  = checksum_q;
	assign too_long  = too_long_q;

	assign prod_full = rd_entry.word * rd_entry.weight;
	assign sum_next  = sum_q + prod_s1;
	assign mix_in    = (fin_s2 ^ HASH_SEED) ^ (fin_s2 >> 16);
	assign shuf_in   = mix_s3 ^ (mix_s3 >> 4);
	assign mul_full  = shuf_in * HASH_MUL;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= prod_full[WORD_W-1:0];
			last_s1 <= rd_entry.last;
			ovf_s1  <= rd_entry.too_long;
			fin_s2  <= sum_next;
			ovf_s2  <= ovf_s1;
			mix_s3  <= (mix_in << 3) + mix_in;
			ovf_s3  <= ovf_s2;
			mul_s4  <= mul_full[WORD_W-1:0];
			ovf_s4  <= ovf_s3;
			if (valid_s4) begin
				checksum_q <= mul_s4 ^ (mul_s4 >> 15);
				too_long_q <= ovf_s4;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
			sum_q       <= '0;
		end else if (adv) begin
			valid_s1    <= !fifo_status.empty;
			valid_s2    <= valid_s1 && last_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
			if (valid_s1) begin
				sum_q <= last_s1 ? '0 : sum_next;
			end
		end
	end

endmodule
